@@ design/slipd_pkg.sv @@
// Shared types, constants and CRC helper for the SLIP frame decoder.
package slipd_pkg;

	// Sizes
	localparam int BUFFER_BYTES  = 128;
	localparam int MAX_PAYLOAD   = 64;
	localparam int HEADER_BYTES  = 4;
	localparam int TRAILER_BYTES = 4;

	localparam int BUF_AW = $clog2(BUFFER_BYTES);
	localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
	localparam int HDR_AW = $clog2(HEADER_BYTES);
	localparam int PLEN_W = 7;

	// SLIP codes
	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	// CRC-32, reflected IEEE
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// Descriptor tracker reset value
	localparam logic [7:0] NO_DESCRIPTOR = 8'hFF;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DESC_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DESC = 2'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_CRC      = 3'd1,
		ST_SHORT    = 3'd2,
		ST_HEADER   = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_CLOSE,
		CS_EMIT
	} ctrl_state_t;

	// Frame summary kept by the receive side
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             overflow;
		logic [31:0]      crc;
		logic [31:0]      trailer;
		logic [7:0]       version;
		logic [7:0]       length;
		logic [7:0]       descriptor;
		logic [7:0]       report_num;
	} frame_info_t;

	// One result item
	typedef struct packed {
		status_t          status;
		logic [7:0]       report_num;
		logic [PLEN_W-1:0] pkt_len;
		logic [7:0]       data_byte;
		logic             has_data;
		logic             last;
		logic             warn;
		logic [7:0]       descriptor;
	} result_t;

	// Advance the CRC by one byte, LSB first
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

@@ design/slipd_store.sv @@
// Frame byte store: one write port, one registered read port.
module slipd_store (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [slipd_pkg::BUF_AW-1:0] wr_addr,
	input  logic [7:0]                  wr_data,
	input  logic                        rd_en,
	input  logic [slipd_pkg::BUF_AW-1:0] rd_addr,
	output logic [7:0]                  rd_data
);
	import slipd_pkg::*;

	logic [7:0] mem [BUFFER_BYTES];
	logic [7:0] rd_data_q;

	// Write decoded bytes
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/slipd_rx.sv @@
// Receive side: SLIP unescaping, byte store writes, running CRC, header and trailer capture.
module slipd_rx (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_fire,
	input  logic [7:0]                   in_byte,
	input  logic                         frame_clear,
	output logic                         wr_en,
	output logic [slipd_pkg::BUF_AW-1:0] wr_addr,
	output logic [7:0]                   wr_data,
	output logic                         frame_end,
	output slipd_pkg::frame_info_t       info
);
	import slipd_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             esc_q;
	logic             ovf_q;
	logic [31:0]      crc_q;
	logic [31:0]      trailer_q;
	logic [7:0]       hdr_q [HEADER_BYTES];

	logic       store_req;
	logic [7:0] store_val;
	logic       full;

	// Decode one received byte
	always_comb begin
		store_req = 1'b0;
		store_val = in_byte;
		frame_end = 1'b0;
		if (in_fire) begin
			if (esc_q) begin
				store_req = 1'b1;
				if (in_byte == SLIP_ESC_END)
					store_val = SLIP_END;
				else if (in_byte == SLIP_ESC_ESC)
					store_val = SLIP_ESC;
			end else if (in_byte == SLIP_END) begin
				frame_end = 1'b1;
			end else if (in_byte != SLIP_ESC) begin
				store_req = 1'b1;
			end
		end
	end

	assign full    = count_q >= CNT_W'(BUFFER_BYTES);
	assign wr_en   = store_req && !full;
	assign wr_addr = count_q[BUF_AW-1:0];
	assign wr_data = store_val;

	// Track count, escape, overflow and CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			esc_q   <= 1'b0;
			ovf_q   <= 1'b0;
			crc_q   <= CRC_INIT;
		end else if (frame_clear) begin
			count_q <= '0;
			esc_q   <= 1'b0;
			ovf_q   <= 1'b0;
			crc_q   <= CRC_INIT;
		end else begin
			if (in_fire) begin
				if (esc_q)
					esc_q <= 1'b0;
				else if (in_byte == SLIP_ESC && !ovf_q)
					esc_q <= 1'b1;
			end
			if (store_req && full)
				ovf_q <= 1'b1;
			if (wr_en) begin
				count_q <= count_q + 1'b1;
				// Byte four places back is body, not trailer
				if (count_q >= CNT_W'(TRAILER_BYTES))
					crc_q <= crc32_byte(crc_q, trailer_q[7:0]);
			end
		end
	end

	// Keep the last four bytes and the header bytes
	always_ff @(posedge clk) begin
		if (wr_en) begin
			trailer_q <= {store_val, trailer_q[31:8]};
			if (count_q < CNT_W'(HEADER_BYTES))
				hdr_q[count_q[HDR_AW-1:0]] <= store_val;
		end
	end

	assign info.count      = count_q;
	assign info.overflow   = ovf_q;
	assign info.crc        = crc_q;
	assign info.trailer    = trailer_q;
	assign info.version    = hdr_q[0];
	assign info.length     = hdr_q[1];
	assign info.descriptor = hdr_q[2];
	assign info.report_num = hdr_q[3];

endmodule

@@ design/slipd_ctrl.sv @@
// Frame close checks, payload readout sequencer, config registers and output register.
module slipd_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [slipd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                       cfg_data,
	output logic                             cfg_ready,
	input  logic                             frame_end,
	input  slipd_pkg::frame_info_t           info,
	input  logic [7:0]                       rd_data,
	input  logic                             out_ready,
	output logic                             in_ready,
	output logic                             frame_clear,
	output logic                             rd_en,
	output logic [slipd_pkg::BUF_AW-1:0]     rd_addr,
	output logic                             out_valid,
	output slipd_pkg::result_t               out_result
);
	import slipd_pkg::*;

	ctrl_state_t state_q, state_d;

	logic [7:0]        exp_version_q;
	logic [7:0]        desc_count_q;
	logic [7:0]        active_desc_q;
	logic [7:0]        last_warned_q;
	logic [PLEN_W-1:0] plen_q;
	logic [PLEN_W-1:0] emit_idx_q;
	logic              warn_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [CNT_W-1:0] body;
	logic [CNT_W-1:0] plen;
	logic             crc_ok;
	logic             hdr_bad;
	logic             warn_new;
	logic             out_free;
	logic             load;
	result_t          res_d;
	logic             pkt_ok;
	logic             emit_step;
	logic             emit_last;

	// Frame checks from the captured summary
	assign body     = info.count - CNT_W'(TRAILER_BYTES);
	assign plen     = body - CNT_W'(HEADER_BYTES);
	assign crc_ok   = (info.crc ^ CRC_INIT) == info.trailer;
	assign hdr_bad  = (info.version != exp_version_q)
		|| (CNT_W'(info.length) != plen)
		|| (plen > CNT_W'(MAX_PAYLOAD))
		|| (info.descriptor >= desc_count_q)
		|| (info.report_num == 8'd0 && plen >= CNT_W'(MAX_PAYLOAD));
	assign warn_new = (info.descriptor != active_desc_q)
		&& (info.descriptor != last_warned_q);

	assign out_free  = !out_valid_q || out_ready;
	assign emit_last = emit_idx_q == (plen_q - 1'b1);
	assign cfg_ready = 1'b1;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= CS_IDLE;
		else
			state_q <= state_d;
	end

	// Next state, readout and result selection
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		frame_clear = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = BUF_AW'(HEADER_BYTES);
		load        = 1'b0;
		pkt_ok      = 1'b0;
		emit_step   = 1'b0;
		res_d       = '0;
		res_d.last  = 1'b1;
		case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (frame_end)
					state_d = CS_CLOSE;
			end
			CS_CLOSE: begin
				if (out_free) begin
					frame_clear = 1'b1;
					state_d     = CS_IDLE;
					if (info.overflow) begin
						load         = 1'b1;
						res_d.status = ST_OVERFLOW;
					end else if (info.count <= CNT_W'(TRAILER_BYTES)) begin
						// drop the runt frame silently
					end else if (!crc_ok) begin
						load         = 1'b1;
						res_d.status = ST_CRC;
					end else if (body < CNT_W'(HEADER_BYTES)) begin
						load         = 1'b1;
						res_d.status = ST_SHORT;
					end else if (hdr_bad) begin
						load         = 1'b1;
						res_d.status = ST_HEADER;
					end else begin
						pkt_ok = 1'b1;
						if (plen == '0) begin
							load             = 1'b1;
							res_d.status     = ST_OK;
							res_d.report_num = info.report_num;
							res_d.warn       = warn_new;
							res_d.descriptor = info.descriptor;
						end else begin
							// fetch the first payload byte
							rd_en   = 1'b1;
							state_d = CS_EMIT;
						end
					end
				end
			end
			CS_EMIT: begin
				if (out_free) begin
					load              = 1'b1;
					res_d.status      = ST_OK;
					res_d.report_num  = info.report_num;
					res_d.pkt_len     = plen_q;
					res_d.data_byte   = rd_data;
					res_d.has_data    = 1'b1;
					res_d.last        = emit_last;
					res_d.warn        = warn_q;
					res_d.descriptor  = info.descriptor;
					if (emit_last) begin
						state_d = CS_IDLE;
					end else begin
						emit_step = 1'b1;
						rd_en     = 1'b1;
						rd_addr   = BUF_AW'(HEADER_BYTES) + BUF_AW'(emit_idx_q) + 1'b1;
					end
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_version_q <= 8'd1;
			desc_count_q  <= 8'd1;
			active_desc_q <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_EXP_VERSION: exp_version_q <= cfg_data;
				REG_DESC_COUNT:  desc_count_q  <= cfg_data;
				REG_ACTIVE_DESC: active_desc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Packet bookkeeping and readout counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_warned_q <= NO_DESCRIPTOR;
			emit_idx_q    <= '0;
			plen_q        <= '0;
			warn_q        <= 1'b0;
		end else begin
			if (pkt_ok) begin
				warn_q     <= warn_new;
				plen_q     <= PLEN_W'(plen);
				emit_idx_q <= '0;
				if (warn_new)
					last_warned_q <= info.descriptor;
			end else if (emit_step) begin
				emit_idx_q <= emit_idx_q + 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= res_d;
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

endmodule

@@ design/slip_crc32_frame_decoder.sv @@
// Top level of the SLIP deframer with CRC-32 trailer and header check.
//
// Input stream: one raw SLIP byte per request on s_axis. Bytes are taken one
// per cycle while a frame is being received; escapes are undone and decoded
// bytes go to a 128-byte store. The CRC of the body runs along four bytes
// behind the write pointer, so nothing is scanned at the frame end.
// On END the input stalls and the FSM goes to CS_CLOSE; once the output
// register is free, the frame is checked there and either one status
// request, one empty-payload request, nothing (runt frame), or the payload
// readout starts. A single request is loaded into the output register from
// CS_CLOSE, and the input is held there. Readout reads the store at one byte
// per cycle while the receiver does not stall (registered read port), and
// the input is held until the last payload byte is loaded; the first byte is
// read in CS_CLOSE and reaches the output register from CS_EMIT.
// Output requests are held in an output register; a stalled receiver stalls
// the readout and, through it, the input. The cfg channel is always ready
// and is meant to be written while no frame end is pending.
// Reset clears counters, flags, the FSM and the registers to their defaults;
// the store needs no clearing since only bytes of the current frame are read.
module slip_crc32_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// Output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] report number, [14:8] payload length, [22:15] data_byte,
	// [30:23] packet_descriptor, [31] zero
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,   // last
	// [2:0] status, [3] has_data, [4] descriptor_warning
	output logic [4:0]  m_axis_tuser,
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import slipd_pkg::*;

	logic              in_fire;
	logic              frame_end;
	logic              frame_clear;
	frame_info_t       info;
	logic              wr_en;
	logic [BUF_AW-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [BUF_AW-1:0] rd_addr;
	logic [7:0]        rd_data;
	result_t           res;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	slipd_rx u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.in_byte     (s_axis_tdata),
		.frame_clear (frame_clear),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.frame_end   (frame_end),
		.info        (info)
	);

	slipd_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	slipd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cfg_ready   (cfg_ready),
		.frame_end   (frame_end),
		.info        (info),
		.rd_data     (rd_data),
		.out_ready   (m_axis_tready),
		.in_ready    (s_axis_tready),
		.frame_clear (frame_clear),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.out_valid   (m_axis_tvalid),
		.out_result  (res)
	);

	// Pack the result fields
	assign m_axis_tdata = {1'b0, res.descriptor, res.data_byte, res.pkt_len, res.report_num};
	assign m_axis_tuser = {res.warn, res.has_data, res.status};
	assign m_axis_tlast = res.last;

endmodule
